@@ hw/rtl/saq_pkg.sv @@
// ----------------------------------------------------------------------------
// saq_pkg
// Shared types, constants and helper functions of the sorted alarm queue.
// ----------------------------------------------------------------------------
package saq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned DELAY_W         = 16;
  localparam int unsigned TAG_W           = 16;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned NCNT_W          = $clog2(MAX_RESULTS);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FIRED  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_INS  = 4'b0100,
    ST_POP  = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch deadline and tag of an arriving item
    logic tick;   // advance the time counter
    logic cmp;    // register the insert position vector
    logic ins;    // write the new entry into the row
    logic pop;    // drop the head entry
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             full;
    logic             head_due;
    logic             next_due;
    logic [TAG_W-1:0] head_tag;
    logic [TAG_W-1:0] new_tag;
  } dp_stat_t;

  // controller to output stage
  typedef struct packed {
    logic             load;
    kind_e            kind;
    logic [TAG_W-1:0] tag;
    logic             last;
  } obuf_ld_t;

  // a strictly later than b in modulo 2^32 signed order
  function automatic logic later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = b - a;
    return diff[TIME_W-1];
  endfunction

  // deadline d reached at time t
  function automatic logic reached(logic [TIME_W-1:0] d, logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] diff;
    diff = d - t;
    return (diff == '0) || diff[TIME_W-1];
  endfunction

endpackage

@@ hw/rtl/sorted_alarm_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_alarm_queue_top
// Alarm queue kept sorted by absolute deadline.
//
// Slave stream: tuser selects insert (0) or tick (1); tdata carries the delay
// and the tag of an insert. An insert yields one item: accepted or rejected
// when the queue is full, always with tlast set. A tick advances the 32-bit
// time counter and fires every due alarm head first, at most 16 per tick,
// tlast on the final one; a tick with nothing due yields no item.
// Steps: an insert is accepted, compared against every cell, then written
// into the row by shift-in. A tick fires its due alarms one at a time
// through the single head-pop path of the cell row. One item is in work at
// a time.
// Results leave through one output register; a new input item is taken while
// the last result still waits there. When the receiver stalls, the sequencer
// holds until the register frees up. Reset clears the time counter, the
// entry count and the output valid; the cells need no clearing.
// ----------------------------------------------------------------------------
module sorted_alarm_queue_top #(
  parameter int unsigned QUEUE_DEPTH = saq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] delay, [31:16] tag
  input  logic [0:0]  s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] fired_tag
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last
);

  saq_pkg::dp_cmd_t  cmd;
  saq_pkg::dp_stat_t stat;
  saq_pkg::obuf_ld_t out_ld;
  logic              out_free;

  saq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i[0]),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .out_free_i (out_free),
    .out_ld_o   (out_ld)
  );

  saq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .delay_i (s_axis_tdata_i[15:0]),
    .tag_i   (s_axis_tdata_i[31:16]),
    .stat_o  (stat)
  );

  saq_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (out_ld),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .kind_o  (m_axis_tuser_o),
    .tag_o   (m_axis_tdata_o),
    .last_o  (m_axis_tlast_o)
  );

endmodule

@@ hw/rtl/saq_datapath.sv @@
// ----------------------------------------------------------------------------
// saq_datapath
// Time counter, sorted row of alarm cells and insert position logic.
// ----------------------------------------------------------------------------
module saq_datapath #(
  parameter int unsigned QUEUE_DEPTH = saq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  saq_pkg::dp_cmd_t             cmd_i,
  input  logic [saq_pkg::DELAY_W-1:0]  delay_i,
  input  logic [saq_pkg::TAG_W-1:0]    tag_i,
  output saq_pkg::dp_stat_t            stat_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LVL_N = $clog2(QUEUE_DEPTH);

  logic [saq_pkg::TIME_W-1:0] now_q, now_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [saq_pkg::TIME_W-1:0] dl_q;
  logic [saq_pkg::TAG_W-1:0]  ntag_q;
  logic [QUEUE_DEPTH-1:0]     pos_q;

  logic [saq_pkg::TIME_W-1:0] dl_cell_q  [QUEUE_DEPTH];
  logic [saq_pkg::TAG_W-1:0]  tag_cell_q [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0]     pfx [LVL_N+1];

  // a cell is a candidate when its deadline is strictly later than the new
  // one or when it lies past the filled part; the prefix OR marks the cells
  // that shift, its first set bit takes the new entry
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pfx[0][i] = saq_pkg::later_than(dl_cell_q[i], dl_q) || (CNT_W'(i) >= count_q);
    end
    for (int l = 0; l < LVL_N; l++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i >= (1 << l)) begin
          pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
        end else begin
          pfx[l+1][i] = pfx[l][i];
        end
      end
    end
  end

  always_comb begin
    now_d   = now_q;
    count_d = count_q;
    if (cmd_i.tick) begin
      now_d = now_q + saq_pkg::TIME_W'(1);
    end
    if (cmd_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      count_q <= '0;
    end else begin
      now_q   <= now_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dl_q   <= now_q + saq_pkg::TIME_W'(delay_i);
      ntag_q <= tag_i;
    end
    if (cmd_i.cmp) begin
      pos_q <= pfx[LVL_N];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd_i.ins) begin
        if (i == 0) begin
          if (pos_q[0]) begin
            dl_cell_q[0]  <= dl_q;
            tag_cell_q[0] <= ntag_q;
          end
        end else if (pos_q[i] && !pos_q[i-1]) begin
          dl_cell_q[i]  <= dl_q;
          tag_cell_q[i] <= ntag_q;
        end else if (pos_q[i]) begin
          dl_cell_q[i]  <= dl_cell_q[i-1];
          tag_cell_q[i] <= tag_cell_q[i-1];
        end
      end else if (cmd_i.pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          dl_cell_q[i]  <= dl_cell_q[i+1];
          tag_cell_q[i] <= tag_cell_q[i+1];
        end
      end
    end
  end

  assign stat_o.full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.head_due = (count_q != '0) && saq_pkg::reached(dl_cell_q[0], now_q);
  assign stat_o.next_due = (count_q > CNT_W'(1)) && saq_pkg::reached(dl_cell_q[1], now_q);
  assign stat_o.head_tag = tag_cell_q[0];
  assign stat_o.new_tag  = ntag_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins && !stat_o.full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not add one entry");
`endif

endmodule

@@ hw/rtl/saq_ctrl.sv @@
// ----------------------------------------------------------------------------
// saq_ctrl
// Sequencer for insert and tick items; drives the datapath and output stage.
// ----------------------------------------------------------------------------
module saq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  input  saq_pkg::dp_stat_t  stat_i,
  output saq_pkg::dp_cmd_t   cmd_o,
  input  logic               out_free_i,
  output saq_pkg::obuf_ld_t  out_ld_o
);

  saq_pkg::state_e                 state_q, state_d;
  logic [saq_pkg::NCNT_W-1:0]      n_q, n_d;
  logic                            more;

  assign in_ready_o = (state_q == saq_pkg::ST_IDLE);
  // another alarm fires after this one only if due and under the per-tick cap
  assign more = stat_i.next_due &&
                (n_q < saq_pkg::NCNT_W'(saq_pkg::MAX_RESULTS - 1));

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    cmd_o         = '0;
    out_ld_o      = '0;
    out_ld_o.kind = saq_pkg::KIND_ACCEPT;
    case (state_q)
      saq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_op_i == saq_pkg::OP_TICK) begin
            cmd_o.tick = 1'b1;
            n_d        = '0;
            state_d    = saq_pkg::ST_POP;
          end else begin
            state_d = saq_pkg::ST_CMP;
          end
        end
      end
      saq_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = saq_pkg::ST_INS;
      end
      saq_pkg::ST_INS: begin
        if (out_free_i) begin
          out_ld_o.load = 1'b1;
          out_ld_o.kind = stat_i.full ? saq_pkg::KIND_REJECT : saq_pkg::KIND_ACCEPT;
          out_ld_o.tag  = stat_i.new_tag;
          out_ld_o.last = 1'b1;
          cmd_o.ins     = !stat_i.full;
          state_d       = saq_pkg::ST_IDLE;
        end
      end
      saq_pkg::ST_POP: begin
        if (!stat_i.head_due) begin
          state_d = saq_pkg::ST_IDLE;
        end else if (out_free_i) begin
          out_ld_o.load = 1'b1;
          out_ld_o.kind = saq_pkg::KIND_FIRED;
          out_ld_o.tag  = stat_i.head_tag;
          out_ld_o.last = !more;
          cmd_o.pop     = 1'b1;
          n_d           = n_q + saq_pkg::NCNT_W'(1);
          if (!more) begin
            state_d = saq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = saq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= saq_pkg::ST_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld_o.load |-> out_free_i)
    else $error("result loaded into a busy output stage");

  a_pop_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> stat_i.head_due && out_ld_o.kind == saq_pkg::KIND_FIRED)
    else $error("head dropped without firing");
`endif

endmodule

@@ hw/rtl/saq_obuf.sv @@
// ----------------------------------------------------------------------------
// saq_obuf
// Output register for result items on the master stream side.
// ----------------------------------------------------------------------------
module saq_obuf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  saq_pkg::obuf_ld_t          ld_i,
  output logic                       free_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [saq_pkg::KIND_W-1:0] kind_o,
  output logic [saq_pkg::TAG_W-1:0]  tag_o,
  output logic                       last_o
);

  logic                       valid_q, valid_d;
  logic [saq_pkg::KIND_W-1:0] kind_q;
  logic [saq_pkg::TAG_W-1:0]  tag_q;
  logic                       last_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = ld_i.load || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.load) begin
      kind_q <= ld_i.kind;
      tag_q  <= ld_i.tag;
      last_q <= ld_i.last;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign tag_o   = tag_q;
  assign last_o  = last_q;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted alarm queue. A directed table covers
// empty ticks, zero and maximum delays, equal deadlines, a full queue and a
// burst of alarms due on one tick. Random items follow, in insert-heavy,
// balanced and tick-heavy phases. A local model of the queue predicts every
// result item, and each item the block delivers is compared with it in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH       = saq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned DIR_ITEMS    = 24;
  localparam int unsigned RAND_ITEMS   = 186;
  localparam int unsigned CALM_ITEMS   = 30;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned SHOW_LIMIT   = 10;

  typedef struct packed {
    saq_pkg::op_e   op;
    logic [15:0]    delay;
    logic [15:0]    tag;
    logic           typed;   // kind below is the known answer for this insert
    saq_pkg::kind_e kind;
  } alarm_cmd_t;

  typedef struct packed {
    saq_pkg::kind_e kind;
    logic [15:0]    tag;
    logic           last;
  } alarm_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;    // [15:0] delay, [31:16] tag
  logic [0:0]  s_axis_tuser_i;    // [0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;    // [15:0] fired_tag
  logic [1:0]  m_axis_tuser_o;    // [1:0] kind
  logic        m_axis_tlast_o;

  // local copy of the queue state
  logic [31:0]   clock_now;
  logic [31:0]   due_at [QDEPTH];
  logic [15:0]   tag_at [QDEPTH];
  int unsigned   n_armed;

  alarm_result_t pending_alarm_results [$];
  alarm_cmd_t    dir_table [DIR_ITEMS];

  int unsigned   mismatch_count;
  int unsigned   idle_cycles;
  bit            calm_tail;
  bit            long_hold_req;

  sorted_alarm_queue_top #(
    .QUEUE_DEPTH (QDEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // a strictly later than b, signed difference modulo 2^32
  function automatic logic deadline_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = b - a;
    return diff[31];
  endfunction

  function automatic logic deadline_hit(logic [31:0] d, logic [31:0] t);
    logic [31:0] diff;
    diff = d - t;
    return (diff == 32'd0) || diff[31];
  endfunction

  task automatic advance_alarm_model(input alarm_cmd_t cmd);
    logic [31:0]   dl;
    int unsigned   pos;
    int unsigned   nf;
    alarm_result_t res;
    if (cmd.op == saq_pkg::OP_INSERT) begin
      res.tag  = cmd.tag;
      res.last = 1'b1;
      if (n_armed >= QDEPTH) begin
        res.kind = saq_pkg::KIND_REJECT;
      end else begin
        dl  = clock_now + 32'(cmd.delay);
        pos = 0;
        while (pos < n_armed && !deadline_after(due_at[pos], dl)) pos++;
        for (int unsigned i = n_armed; i > pos; i--) begin
          due_at[i] = due_at[i-1];
          tag_at[i] = tag_at[i-1];
        end
        due_at[pos] = dl;
        tag_at[pos] = cmd.tag;
        n_armed++;
        res.kind = saq_pkg::KIND_ACCEPT;
      end
      if (cmd.typed) res.kind = cmd.kind;
      pending_alarm_results.push_back(res);
    end else begin
      clock_now = clock_now + 32'd1;
      nf = 0;
      while (nf < saq_pkg::MAX_RESULTS && n_armed > 0 &&
             deadline_hit(due_at[0], clock_now)) begin
        res.kind = saq_pkg::KIND_FIRED;
        res.tag  = tag_at[0];
        for (int unsigned i = 1; i < n_armed; i++) begin
          due_at[i-1] = due_at[i];
          tag_at[i-1] = tag_at[i];
        end
        n_armed--;
        nf++;
        // mark last when the head will not fire on this tick
        res.last = !(nf < saq_pkg::MAX_RESULTS && n_armed > 0 &&
                     deadline_hit(due_at[0], clock_now));
        pending_alarm_results.push_back(res);
      end
    end
  endtask

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic offer_alarm_cmd(input alarm_cmd_t cmd);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {cmd.tag, cmd.delay};
    s_axis_tuser_i  <= cmd.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    advance_alarm_model(cmd);
    @(negedge clk_i);
  endtask

  // sender
  initial begin
    alarm_cmd_t  cmd;
    int unsigned ins_pct;
    int unsigned pick;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    rst_ni          = 1'b0;
    clock_now       = '0;
    n_armed         = 0;
    mismatch_count  = 0;
    calm_tail       = 1'b0;
    long_hold_req   = 1'b0;

    dir_table = '{
      '{saq_pkg::OP_TICK,   16'hFFFF, 16'hFFFF, 1'b0, saq_pkg::KIND_ACCEPT},  // nothing due
      '{saq_pkg::OP_INSERT, 16'h0000, 16'h0000, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0, saq_pkg::KIND_ACCEPT},  // zero delay fires
      '{saq_pkg::OP_TICK,   16'h5555, 16'hAAAA, 1'b0, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h1001, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0000, 16'h1002, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h1003, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0002, 16'h1004, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0000, 16'h1005, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h1006, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h1007, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0000, 16'h1008, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0002, 16'h1009, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h100A, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0000, 16'h100B, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h100C, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h100D, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0000, 16'h100E, 1'b1, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h8000, 16'h8000, 1'b1, saq_pkg::KIND_ACCEPT},  // queue now full
      '{saq_pkg::OP_INSERT, 16'h0001, 16'h1234, 1'b1, saq_pkg::KIND_REJECT},
      '{saq_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0, saq_pkg::KIND_ACCEPT},  // twelve due
      '{saq_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0, saq_pkg::KIND_ACCEPT},
      '{saq_pkg::OP_INSERT, 16'h0000, 16'h7FFF, 1'b1, saq_pkg::KIND_ACCEPT}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ITEMS; i++) offer_alarm_cmd(dir_table[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 40) long_hold_req = 1'b1;
      if (i >= RAND_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
      case ((i / 30) % 3)
        0:       ins_pct = 80;
        1:       ins_pct = 50;
        default: ins_pct = 20;
      endcase
      cmd.op = ($urandom_range(0, 99) < ins_pct) ? saq_pkg::OP_INSERT : saq_pkg::OP_TICK;
      pick   = $urandom_range(0, 99);
      if (pick < 85)      cmd.delay = 16'($urandom_range(0, 12));
      else if (pick < 98) cmd.delay = 16'($urandom_range(0, 255));
      else                cmd.delay = 16'($urandom);
      cmd.tag   = 16'($urandom);
      cmd.typed = 1'b0;
      cmd.kind  = saq_pkg::KIND_ACCEPT;
      offer_alarm_cmd(cmd);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_alarm_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off, none in the tail
  initial begin
    bit held_long;
    held_long       = 1'b0;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !held_long) begin
        held_long = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // compare each delivered item with the oldest prediction
  always @(posedge clk_i) begin
    alarm_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_alarm_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("%0t: unexpected item kind %0d tag %h last %0b", $realtime,
                   m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        want = pending_alarm_results.pop_front();
        if (m_axis_tuser_o !== want.kind || m_axis_tdata_o !== want.tag ||
            m_axis_tlast_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("%0t: expected kind %0d tag %h last %0b, got kind %0d tag %h last %0b",
                     $realtime, want.kind, want.tag, want.last,
                     m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        end
      end
    end
  end

  // end the run when no item moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
